// File: sv/owbm_pkg.sv
// shared types, codes and helpers for the 1-wire bus master
package owbm_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int CNT_W         = 10;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 10;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_LOW      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESENCE_SAMPLE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_TAIL     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_LOW      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_LOW       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_SAMPLE    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT           = 3'd6;

   // request operation codes
   localparam logic [2:0] OP_TICK       = 3'd0;
   localparam logic [2:0] OP_RESET      = 3'd1;
   localparam logic [2:0] OP_SEND       = 3'd2;
   localparam logic [2:0] OP_RECV       = 3'd3;
   localparam logic [2:0] OP_CONVERT    = 3'd4;
   localparam logic [2:0] OP_READ_TEMP  = 3'd5;

   // rom command bytes
   localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
   localparam logic [7:0] CMD_CONVERT_T  = 8'h44;
   localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

   typedef struct packed {
      logic [9:0] reset_low_us;
      logic [7:0] presence_sample_us;
      logic [9:0] reset_tail_us;
      logic [5:0] short_low_us;
      logic [7:0] long_low_us;
      logic [5:0] read_sample_us;
      logic [7:0] slot_us;
   } cfg_type;

   typedef struct packed {
      logic        drive_low;
      logic        busy_res;
      logic        done_res;
      logic        presence_level;
      logic [7:0]  rx_byte;
      logic [15:0] temperature_word;
   } res_type;

   // a zero timing value behaves as one microsecond
   function automatic logic [CNT_W-1:0] dur(input logic [CNT_W-1:0] v);
      dur = (v == '0) ? CNT_W'(1) : v;
   endfunction

endpackage

// File: sv/one_wire_bus_master.sv
// 1-wire bus master top level
//
// Every request beat is one microsecond of bus time: req_op selects a tick
// (0), bus reset (1), send byte (2), receive byte (3), start conversion (4)
// or read temperature (5); req_line_level is the bus level seen during that
// microsecond. A command starting while another runs is treated as a tick.
// Each request beat yields exactly one response beat with the drive level,
// busy and done flags, the presence sample, the receive shift register and
// the last temperature word.
// The accept edge loads the input register; the sequencer step then loads
// the result register and sets response valid once that register is free
// or being taken, so a stall on rsp_ready can hold the beat between them.
// Throughput is one beat per cycle while the receiver keeps rsp_ready high;
// while a result waits, the input register still takes a beat if empty.
// When the receiver holds rsp_ready low, the result register holds and
// req_ready drops once the input register is also full; no beat is lost.
// Synchronous reset empties both registers, idles the sequencer and loads
// the default slot timings; the csr_ port writes a timing register, and the
// user must use it only while no beat is in flight, unchecked by the block.
module one_wire_bus_master
   import owbm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_op,
   input  logic [7:0]            req_tx_byte,
   input  logic                  req_line_level,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_drive_low,
   output logic                  rsp_busy_res,
   output logic                  rsp_done_res,
   output logic                  rsp_presence_level,
   output logic [7:0]            rsp_rx_byte,
   output logic [15:0]           rsp_temperature_word,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   res_type    res, res_ff;
   logic       in_valid_ff, in_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] op_ff;
   logic [7:0] tx_byte_ff;
   logic       line_level_ff;
   logic       advance, step_en, req_take;

   owbm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   owbm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step_en    (step_en),
      .op         (op_ff),
      .tx_byte    (tx_byte_ff),
      .line_level (line_level_ff),
      .res        (res)
   );

   // pipeline flow control
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step_en   = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) in_valid_in = 1'b1;
      else if (step_en) in_valid_in = 1'b0;
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input beat register
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff         <= req_op;
         tx_byte_ff    <= req_tx_byte;
         line_level_ff <= req_line_level;
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (step_en) res_ff <= res;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_drive_low        = res_ff.drive_low;
   assign rsp_busy_res         = res_ff.busy_res;
   assign rsp_done_res         = res_ff.done_res;
   assign rsp_presence_level   = res_ff.presence_level;
   assign rsp_rx_byte          = res_ff.rx_byte;
   assign rsp_temperature_word = res_ff.temperature_word;

endmodule

// File: sv/owbm_csr.sv
// timing configuration registers of the 1-wire bus master
module owbm_csr
   import owbm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   // decode the write index
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_RESET_LOW:       cfg_in.reset_low_us       = csr_wdata[9:0];
            CSR_PRESENCE_SAMPLE: cfg_in.presence_sample_us = csr_wdata[7:0];
            CSR_RESET_TAIL:      cfg_in.reset_tail_us      = csr_wdata[9:0];
            CSR_SHORT_LOW:       cfg_in.short_low_us       = csr_wdata[5:0];
            CSR_LONG_LOW:        cfg_in.long_low_us        = csr_wdata[7:0];
            CSR_READ_SAMPLE:     cfg_in.read_sample_us     = csr_wdata[5:0];
            CSR_SLOT:            cfg_in.slot_us            = csr_wdata[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_us       <= 10'd480;
         cfg_ff.presence_sample_us <= 8'd70;
         cfg_ff.reset_tail_us      <= 10'd410;
         cfg_ff.short_low_us       <= 6'd6;
         cfg_ff.long_low_us        <= 8'd60;
         cfg_ff.read_sample_us     <= 6'd9;
         cfg_ff.slot_us            <= 8'd70;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/owbm_core.sv
// bus sequencer: one microsecond of bus time per step
module owbm_core
   import owbm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step_en,
   input  logic [2:0] op,
   input  logic [7:0] tx_byte,
   input  logic       line_level,
   output res_type    res
);

   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_RST_LOW  = 3'd1;
   localparam logic [2:0] PH_RST_REL  = 3'd2;
   localparam logic [2:0] PH_RST_TAIL = 3'd3;
   localparam logic [2:0] PH_WRITE    = 3'd4;
   localparam logic [2:0] PH_READ     = 3'd5;

   localparam logic [2:0] LAST_BIT = 3'(BITS_PER_BYTE - 1);

   logic [2:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] us_counter_ff, us_counter_in;
   logic [2:0]       bit_index_ff, bit_index_in;
   logic [7:0]       shift_out_ff, shift_out_in;
   logic [7:0]       shift_in_ff, shift_in_in;
   logic [2:0]       sequence_step_ff, sequence_step_in;
   logic [2:0]       command_kind_ff, command_kind_in;
   logic [7:0]       low_byte_hold_ff, low_byte_hold_in;
   logic             presence_hold_ff, presence_hold_in;
   logic [15:0]      temperature_hold_ff, temperature_hold_in;

   logic             drive, busy, done, part_end;
   logic [CNT_W-1:0] cnt_inc, slot_len, low_len, sample_at;

   // next state for one microsecond
   always_comb begin
      phase_in            = phase_ff;
      us_counter_in       = us_counter_ff;
      bit_index_in        = bit_index_ff;
      shift_out_in        = shift_out_ff;
      shift_in_in         = shift_in_ff;
      sequence_step_in    = sequence_step_ff;
      command_kind_in     = command_kind_ff;
      low_byte_hold_in    = low_byte_hold_ff;
      presence_hold_in    = presence_hold_ff;
      temperature_hold_in = temperature_hold_ff;
      drive    = 1'b0;
      busy     = 1'b0;
      done     = 1'b0;
      part_end = 1'b0;

      slot_len  = dur({2'b00, cfg.slot_us});
      sample_at = dur({4'b0000, cfg.short_low_us}) + dur({4'b0000, cfg.read_sample_us});
      if (sample_at > slot_len - CNT_W'(1)) sample_at = slot_len - CNT_W'(1);

      // command start from idle
      if (phase_ff == PH_IDLE && op >= OP_RESET && op <= OP_READ_TEMP) begin
         command_kind_in  = op;
         sequence_step_in = 3'd0;
         us_counter_in    = '0;
         if (op == OP_SEND) begin
            phase_in     = PH_WRITE;
            bit_index_in = 3'd0;
            shift_out_in = tx_byte;
         end else if (op == OP_RECV) begin
            phase_in     = PH_READ;
            bit_index_in = 3'd0;
            shift_in_in  = 8'd0;
         end else begin
            phase_in = PH_RST_LOW;
         end
      end

      cnt_inc = us_counter_in + CNT_W'(1);
      low_len = (phase_in == PH_WRITE && !shift_out_in[0])
                ? dur({2'b00, cfg.long_low_us}) : dur({4'b0000, cfg.short_low_us});

      // one microsecond of the active phase
      case (phase_in)
         PH_RST_LOW: begin
            drive = 1'b1;
            us_counter_in = cnt_inc;
            if (cnt_inc >= dur(cfg.reset_low_us)) begin
               phase_in = PH_RST_REL;
               us_counter_in = '0;
            end
         end
         PH_RST_REL: begin
            us_counter_in = cnt_inc;
            if (cnt_inc >= dur({2'b00, cfg.presence_sample_us})) begin
               phase_in = PH_RST_TAIL;
               us_counter_in = '0;
            end
         end
         PH_RST_TAIL: begin
            if (us_counter_in == '0) presence_hold_in = line_level;
            us_counter_in = cnt_inc;
            if (cnt_inc >= dur(cfg.reset_tail_us)) part_end = 1'b1;
         end
         PH_WRITE, PH_READ: begin
            drive = (us_counter_in < low_len);
            if (phase_in == PH_READ && us_counter_in == sample_at)
               shift_in_in = {line_level, shift_in_in[7:1]};
            us_counter_in = cnt_inc;
            if (cnt_inc >= slot_len) begin
               us_counter_in = '0;
               if (phase_in == PH_WRITE) shift_out_in = {1'b0, shift_out_in[7:1]};
               if (bit_index_in == LAST_BIT) part_end = 1'b1;
               else bit_index_in = bit_index_in + 3'd1;
            end
         end
         default: begin
         end
      endcase
      busy = (phase_in != PH_IDLE);

      // advance through the composite command sequence
      if (part_end) begin
         done = 1'b1;
         if (command_kind_in == OP_CONVERT && sequence_step_in < 3'd2) begin
            done         = 1'b0;
            phase_in     = PH_WRITE;
            us_counter_in = '0;
            bit_index_in = 3'd0;
            shift_out_in = (sequence_step_in == 3'd0) ? CMD_SKIP_ROM : CMD_CONVERT_T;
            sequence_step_in = sequence_step_in + 3'd1;
         end else if (command_kind_in == OP_READ_TEMP && sequence_step_in < 3'd4) begin
            done          = 1'b0;
            us_counter_in = '0;
            bit_index_in  = 3'd0;
            if (sequence_step_in < 3'd2) begin
               phase_in     = PH_WRITE;
               shift_out_in = (sequence_step_in == 3'd0) ? CMD_SKIP_ROM : CMD_READ_SCRATCH;
            end else begin
               if (sequence_step_in == 3'd3) low_byte_hold_in = shift_in_in;
               phase_in    = PH_READ;
               shift_in_in = 8'd0;
            end
            sequence_step_in = sequence_step_in + 3'd1;
         end else begin
            if (command_kind_in == OP_READ_TEMP)
               temperature_hold_in = {shift_in_in, low_byte_hold_in};
            phase_in         = PH_IDLE;
            us_counter_in    = '0;
            sequence_step_in = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_IDLE;
         us_counter_ff       <= '0;
         bit_index_ff        <= 3'd0;
         shift_out_ff        <= 8'd0;
         shift_in_ff         <= 8'd0;
         sequence_step_ff    <= 3'd0;
         command_kind_ff     <= 3'd0;
         low_byte_hold_ff    <= 8'd0;
         presence_hold_ff    <= 1'b1;
         temperature_hold_ff <= 16'd0;
      end else if (step_en) begin
         phase_ff            <= phase_in;
         us_counter_ff       <= us_counter_in;
         bit_index_ff        <= bit_index_in;
         shift_out_ff        <= shift_out_in;
         shift_in_ff         <= shift_in_in;
         sequence_step_ff    <= sequence_step_in;
         command_kind_ff     <= command_kind_in;
         low_byte_hold_ff    <= low_byte_hold_in;
         presence_hold_ff    <= presence_hold_in;
         temperature_hold_ff <= temperature_hold_in;
      end
   end

   // result of this microsecond
   assign res.drive_low        = drive;
   assign res.busy_res         = busy;
   assign res.done_res         = done;
   assign res.presence_level   = presence_hold_in;
   assign res.rx_byte          = shift_in_in;
   assign res.temperature_word = temperature_hold_in;

endmodule

// File: sv/owbm_chk.sv
// port-level checks for the 1-wire bus master and their binding
module owbm_chk
   import owbm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_drive_low,
   input logic        rsp_busy_res,
   input logic        rsp_done_res,
   input logic [7:0]  rsp_rx_byte,
   input logic [15:0] rsp_temperature_word
);

   // a completing microsecond is part of a command
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_busy_res)
      else $error("done without busy");

   // the bus is only pulled low inside a command
   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_low |-> rsp_busy_res)
      else $error("bus driven while idle");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat right after reset");

   // a stalled response beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rx_byte)
         && $stable(rsp_temperature_word))
      else $error("stalled response beat changed");

endmodule

bind one_wire_bus_master owbm_chk u_owbm_chk (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_drive_low        (rsp_drive_low),
   .rsp_busy_res         (rsp_busy_res),
   .rsp_done_res         (rsp_done_res),
   .rsp_rx_byte          (rsp_rx_byte),
   .rsp_temperature_word (rsp_temperature_word)
);

// File: verif/tb_top.sv
// self-checking bench for the 1-wire bus master: timed microsecond beats checked against a bus model
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import owbm_pkg::*;

   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;
   localparam int NUM_TIMING_REGS = 7;
   localparam int STALL_LIMIT     = 2000;
   localparam int HOLD_CYCLES     = 300;
   localparam int PHASE_ITEMS     = 70;
   localparam int NUM_PHASES      = 10;
   localparam int SETTLE_BATCH    = 8;
   localparam int LINE_LOW        = 0;
   localparam int LINE_HIGH       = 1;
   localparam int LINE_RANDOM     = 2;

   typedef enum logic [2:0] {
      BUS_IDLE, BUS_RST_LOW, BUS_RST_REL, BUS_RST_TAIL, BUS_WRITE, BUS_READ
   } bus_phase_type;

   typedef enum int {GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH} gap_mode_type;

   typedef struct {
      logic [2:0] op;
      logic [7:0] tx;
      logic       line;
   } us_beat_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [2:0]            req_op = OP_TICK;
   logic [7:0]            req_tx_byte = '0;
   logic                  req_line_level = 1'b1;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_drive_low;
   logic                  rsp_busy_res;
   logic                  rsp_done_res;
   logic                  rsp_presence_level;
   logic [7:0]            rsp_rx_byte;
   logic [15:0]           rsp_temperature_word;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_RESET_LOW;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   one_wire_bus_master dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_tx_byte          (req_tx_byte),
      .req_line_level       (req_line_level),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_drive_low        (rsp_drive_low),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_done_res         (rsp_done_res),
      .rsp_presence_level   (rsp_presence_level),
      .rsp_rx_byte          (rsp_rx_byte),
      .rsp_temperature_word (rsp_temperature_word),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // microsecond beats waiting to be offered, bus status words still owed
   us_beat_type  us_beat_q[$];
   res_type      bus_status_q[$];
   gap_mode_type gap_mode = GAP_NONE;
   bit        req_fired = 1'b0;
   bit        hold_ask = 1'b0;
   int        hold_left = 0;
   int        stuck_cycles = 0;
   int        mismatches = 0;

   // bus model state and its copy of the timing registers
   cfg_type       timing;
   bus_phase_type bus_phase = BUS_IDLE;
   int         us_cnt = 0;
   int         bit_pos = 0;
   logic [7:0] tx_shift = '0;
   logic [7:0] rx_shift = '0;
   int         seq_step = 0;
   logic [2:0] cmd_kind = '0;
   logic [7:0] low_byte = '0;
   logic       presence_bit = 1'b1;
   logic [15:0] temp_word = '0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // a timing register at zero counts as one microsecond
   function automatic int eff_us(int v);
      return (v == 0) ? 1 : v;
   endfunction

   function automatic void load_tx(logic [7:0] b);
      bus_phase = BUS_WRITE;
      us_cnt    = 0;
      bit_pos   = 0;
      tx_shift  = b;
   endfunction

   function automatic void load_rx();
      bus_phase = BUS_READ;
      us_cnt    = 0;
      bit_pos   = 0;
      rx_shift  = '0;
   endfunction

   // move a composite command to its next part; 1 when the command is over
   function automatic bit advance_command();
      if (cmd_kind == OP_CONVERT) begin
         if (seq_step == 0) begin
            seq_step = 1;
            load_tx(CMD_SKIP_ROM);
            return 1'b0;
         end
         if (seq_step == 1) begin
            seq_step = 2;
            load_tx(CMD_CONVERT_T);
            return 1'b0;
         end
      end else if (cmd_kind == OP_READ_TEMP) begin
         if (seq_step == 0) begin
            seq_step = 1;
            load_tx(CMD_SKIP_ROM);
            return 1'b0;
         end
         if (seq_step == 1) begin
            seq_step = 2;
            load_tx(CMD_READ_SCRATCH);
            return 1'b0;
         end
         if (seq_step == 2) begin
            seq_step = 3;
            load_rx();
            return 1'b0;
         end
         if (seq_step == 3) begin
            low_byte = rx_shift;
            seq_step = 4;
            load_rx();
            return 1'b0;
         end
         temp_word = {rx_shift, low_byte};
      end
      bus_phase = BUS_IDLE;
      us_cnt    = 0;
      seq_step  = 0;
      return 1'b1;
   endfunction

   // one microsecond of bus time: returns the status word it produces
   function automatic res_type master_step(logic [2:0] op, logic [7:0] tx, logic line);
      res_type r;
      int      low_us;
      int      sample_at;
      int      slot_len;
      bit      part_end;
      r        = '0;
      part_end = 1'b0;
      if (bus_phase == BUS_IDLE && op >= OP_RESET && op <= OP_READ_TEMP) begin
         cmd_kind = op;
         seq_step = 0;
         if (op == OP_SEND) load_tx(tx);
         else if (op == OP_RECV) load_rx();
         else begin
            bus_phase = BUS_RST_LOW;
            us_cnt    = 0;
         end
      end
      if (bus_phase != BUS_IDLE) begin
         r.busy_res = 1'b1;
         slot_len   = eff_us(int'(timing.slot_us));
         case (bus_phase)
            BUS_RST_LOW: begin
               r.drive_low = 1'b1;
               us_cnt++;
               if (us_cnt >= eff_us(int'(timing.reset_low_us))) begin
                  bus_phase = BUS_RST_REL;
                  us_cnt    = 0;
               end
            end
            BUS_RST_REL: begin
               us_cnt++;
               if (us_cnt >= eff_us(int'(timing.presence_sample_us))) begin
                  bus_phase = BUS_RST_TAIL;
                  us_cnt    = 0;
               end
            end
            BUS_RST_TAIL: begin
               if (us_cnt == 0) presence_bit = line;
               us_cnt++;
               if (us_cnt >= eff_us(int'(timing.reset_tail_us))) part_end = 1'b1;
            end
            default: begin
               // write and read slots share the slot clock
               if (bus_phase == BUS_WRITE && !tx_shift[0])
                  low_us = eff_us(int'(timing.long_low_us));
               else low_us = eff_us(int'(timing.short_low_us));
               r.drive_low = (us_cnt < low_us);
               if (bus_phase == BUS_READ) begin
                  sample_at = eff_us(int'(timing.short_low_us))
                              + eff_us(int'(timing.read_sample_us));
                  if (sample_at > slot_len - 1) sample_at = slot_len - 1;
                  if (us_cnt == sample_at) rx_shift = {line, rx_shift[7:1]};
               end
               us_cnt++;
               if (us_cnt >= slot_len) begin
                  us_cnt = 0;
                  if (bus_phase == BUS_WRITE) tx_shift = tx_shift >> 1;
                  if (bit_pos == BITS_PER_BYTE - 1) part_end = 1'b1;
                  else bit_pos++;
               end
            end
         endcase
         if (part_end) r.done_res = advance_command();
      end
      r.presence_level   = presence_bit;
      r.rx_byte          = rx_shift;
      r.temperature_word = temp_word;
      return r;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // request driver: new beat only once the previous one is gone
   always @(negedge clock) begin : req_driver
      us_beat_type b;
      bit          gap;
      if (!reset && (!req_valid || req_fired)) begin
         gap = (gap_mode == GAP_SENDER && $urandom_range(99) < 59) ||
               (gap_mode == GAP_BOTH && $urandom_range(99) < 20);
         if (us_beat_q.size() != 0 && !gap) begin
            b = us_beat_q.pop_front();
            req_valid      <= 1'b1;
            req_op         <= b.op;
            req_tx_byte    <= b.tx;
            req_line_level <= b.line;
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_fired = 1'b0;
   end

   // response ready: random stalls plus one long hold-off on request
   always @(negedge clock) begin : rsp_driver
      if (hold_ask) begin
         hold_left = HOLD_CYCLES;
         hold_ask  = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !((gap_mode == GAP_RECEIVER && $urandom_range(99) < 59) ||
                        (gap_mode == GAP_BOTH && $urandom_range(99) < 20));
      end
   end

   // monitor: check each response beat, predict each request beat, watchdog
   always @(posedge clock) begin : monitor
      res_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (bus_status_q.size() == 0) begin
               $error("response beat with nothing outstanding");
               mismatches++;
            end else begin
               want = bus_status_q.pop_front();
               check_field("drive_low", 16'(want.drive_low), 16'(rsp_drive_low));
               check_field("busy_res", 16'(want.busy_res), 16'(rsp_busy_res));
               check_field("done_res", 16'(want.done_res), 16'(rsp_done_res));
               check_field("presence_level", 16'(want.presence_level),
                           16'(rsp_presence_level));
               check_field("rx_byte", 16'(want.rx_byte), 16'(rsp_rx_byte));
               check_field("temperature_word", want.temperature_word, rsp_temperature_word);
            end
         end
         if (req_valid && req_ready) begin
            bus_status_q.push_back(master_step(req_op, req_tx_byte, req_line_level));
            req_fired = 1'b1;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stuck_cycles = 0;
         else stuck_cycles++;
         if (stuck_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic push_beat(logic [2:0] op, logic [7:0] tx, logic line);
      us_beat_type b;
      b.op   = op;
      b.tx   = tx;
      b.line = line;
      us_beat_q.push_back(b);
   endtask

   task automatic drain();
      while (us_beat_q.size() != 0 || req_valid || bus_status_q.size() != 0)
         @(posedge clock);
   endtask

   // tick until the running command is over, then let the pipeline empty
   task automatic settle(int line_mode);
      logic line;
      drain();
      while (bus_phase != BUS_IDLE) begin
         for (int i = 0; i < SETTLE_BATCH; i++) begin
            if (line_mode == LINE_RANDOM) line = 1'($urandom_range(1));
            else line = (line_mode == LINE_HIGH);
            push_beat(OP_TICK, 8'($urandom_range(255)), line);
         end
         drain();
      end
      repeat (6) @(posedge clock);
   endtask

   // write every timing register, only while no beat is in flight
   task automatic program_timing(cfg_type c);
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] val;
      for (int i = 0; i < NUM_TIMING_REGS; i++) begin
         idx = i[CSR_IDX_W-1:0];
         case (idx)
            CSR_RESET_LOW:       val = c.reset_low_us;
            CSR_PRESENCE_SAMPLE: val = CSR_DATA_W'(c.presence_sample_us);
            CSR_RESET_TAIL:      val = c.reset_tail_us;
            CSR_SHORT_LOW:       val = CSR_DATA_W'(c.short_low_us);
            CSR_LONG_LOW:        val = CSR_DATA_W'(c.long_low_us);
            CSR_READ_SAMPLE:     val = CSR_DATA_W'(c.read_sample_us);
            default:             val = CSR_DATA_W'(c.slot_us);
         endcase
         @(negedge clock);
         csr_write_en <= 1'b1;
         csr_index    <= idx;
         csr_wdata    <= val;
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
      timing = c;
   endtask

   initial begin : stimulus
      cfg_type c;
      logic [2:0] op;
      timing = {10'd480, 8'd70, 10'd410, 6'd6, 8'd60, 6'd9, 8'd70};
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: short timings so every command finishes quickly
      program_timing({10'd3, 8'd2, 10'd3, 6'd1, 8'd3, 6'd1, 8'd4});
      push_beat(OP_TICK, 8'h00, 1'b0);
      push_beat(OP_SPARE_6, 8'hA5, 1'b1);
      push_beat(OP_SPARE_7, 8'h5A, 1'b0);
      // reset with a device answering, a second command ignored while busy
      push_beat(OP_RESET, 8'hFF, 1'b0);
      push_beat(OP_READ_TEMP, 8'h00, 1'b0);
      settle(LINE_LOW);
      // reset with nobody on the bus
      push_beat(OP_RESET, 8'h00, 1'b1);
      settle(LINE_HIGH);
      push_beat(OP_SEND, 8'h00, 1'b1);
      settle(LINE_HIGH);
      push_beat(OP_SEND, 8'hFF, 1'b0);
      push_beat(OP_SEND, 8'h3C, 1'b1);
      settle(LINE_LOW);
      push_beat(OP_RECV, 8'hFF, 1'b1);
      settle(LINE_HIGH);
      // a fresh receive clears the shift register
      push_beat(OP_RECV, 8'h00, 1'b0);
      settle(LINE_LOW);
      push_beat(OP_CONVERT, 8'h81, 1'b1);
      settle(LINE_RANDOM);
      push_beat(OP_READ_TEMP, 8'h7E, 1'b0);
      settle(LINE_RANDOM);
      push_beat(OP_READ_TEMP, 8'h00, 1'b1);
      settle(LINE_HIGH);

      // random phases over timing corners and idle patterns
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            // every register at zero behaves as one
            1: c = '0;
            // low time at or beyond the slot keeps the line low all slot
            2: c = {10'd5, 8'd3, 10'd4, 6'd63, 8'd255, 6'd5, 8'd6};
            // read sample point beyond the slot end
            3: c = {10'd4, 8'd2, 10'd5, 6'd3, 8'd4, 6'd63, 8'd5};
            5: c = {10'd480, 8'd70, 10'd410, 6'd6, 8'd60, 6'd9, 8'd70};
            6: c = {10'd1023, 8'd255, 10'd1023, 6'd63, 8'd255, 6'd63, 8'd255};
            7: c = {10'd1, 8'd1, 10'd1, 6'd1, 8'd1, 6'd1, 8'd2};
            default: c = {10'($urandom_range(12)), 8'($urandom_range(6)),
                          10'($urandom_range(10)), 6'($urandom_range(5)),
                          8'($urandom_range(9)), 6'($urandom_range(5)),
                          8'($urandom_range(14))};
         endcase
         program_timing(c);
         gap_mode = gap_mode_type'(p % 4);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(99) < 12) op = 3'($urandom_range(7, 1));
            else op = OP_TICK;
            push_beat(op, 8'($urandom_range(255)), 1'($urandom_range(1)));
         end
         // long receiver hold-off so the input side backs up
         if (p == 0 || p == 4) begin
            @(posedge clock);
            hold_ask = 1'b1;
         end
         // long timings: a running command carries on into the next phase
         if (p == 5 || p == 6) drain();
         else settle(LINE_RANDOM);
      end

      gap_mode = GAP_NONE;
      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && bus_status_q.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
